[hdl/pcds_pkg.sv]
`default_nettype none
package pcds_pkg;

  // Field widths
  localparam int unsigned COST_W = 7;
  localparam int unsigned RAD_W  = 6;
  localparam int unsigned CRD_W  = 10;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned FRAC_W = 10;
  // t runs 0..1.0 in Q10
  localparam int unsigned T_W    = FRAC_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_STAMP = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_COST_MIN  = 2'd0,
    REG_COST_MAX  = 2'd1,
    REG_INNER_RAD = 2'd2,
    REG_OUTER_RAD = 2'd3
  } reg_idx_t;

  // Handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

[hdl/pcds_in_if.sv]
`default_nettype none
interface pcds_in_if
  import pcds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CRD_W-1:0]  col;
  logic [CRD_W-1:0]  row;

  modport source (output valid, mode, col, row, input ready);
  modport sink   (input valid, mode, col, row, output ready);
endinterface
`default_nettype wire

[hdl/pcds_out_if.sv]
`default_nettype none
interface pcds_out_if
  import pcds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              in_grid;

  modport source (output valid, cost, in_grid, input ready);
  modport sink   (input valid, cost, in_grid, output ready);
endinterface
`default_nettype wire

[hdl/pcds_cfg_if.sv]
`default_nettype none
interface pcds_cfg_if
  import pcds_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [COST_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/pcds_sqrt.sv]
`default_nettype none
// Digit-by-digit integer square root, one result bit per cycle.
module pcds_sqrt
  import pcds_pkg::*;
#(
  parameter int unsigned IN_W = 34
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [IN_W-1:0]   radicand,
  output unit_stat_t             stat,
  output logic [IN_W/2-1:0]      root
);
  localparam int unsigned HW = IN_W / 2;
  localparam int unsigned CW = $clog2(HW + 1);

  logic [IN_W-1:0] val;
  logic [HW+1:0]   rem;
  logic [HW+1:0]   rem_sh;
  logic [HW+1:0]   trial;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic            ge;

  // Bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem[HW-1:0], val[IN_W-1:IN_W-2]};
    trial  = {root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(HW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[IN_W-3:0], 2'b00};
      if (ge) begin
        rem  <= rem_sh - trial;
        root <= {root[HW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[HW-2:0], 1'b0};
      end
    end
  end

  assign stat = '{busy: busy, done: done};
endmodule
`default_nettype wire

[hdl/pcds_div.sv]
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module pcds_div
  import pcds_pkg::*;
#(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output unit_stat_t         stat,
  output logic [DW-1:0]      quot
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW-1:0] dvs;
  logic [VW:0]   rem;
  logic [VW:0]   rem_sh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  assign rem_sh = {rem[VW-1:0], quot[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Shift-subtract step
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvs  <= divisor;
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem  <= rem_sh - {1'b0, dvs};
        quot <= {quot[DW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[DW-2:0], 1'b0};
      end
    end
  end

  assign stat = '{busy: busy, done: done};
endmodule
`default_nettype wire

[hdl/path_costmap_disc_stamper_top.sv]
`default_nettype none
// Cost grid stamper. The grid (GRID_WIDTH x GRID_WIDTH cells of 7 bits) sits in one
// synchronous RAM and is undefined until a clear. One item at a time; a clear makes one
// RAM write per cell. A stamp scans each of the (2R)^2 offsets around the centre
// (R = saturated outer radius); cells inside the inner radius are written as they are
// scanned. A ring cell instead runs a square root and a divide, each one bit per cycle,
// then a read-modify-write, which it does straight away when the radii are equal. A
// read fetches its cell from the RAM. A finished result sits in an output register, so
// the next item may enter while it waits to be taken; that item then holds in its last
// cycle until the register is free.
module path_costmap_disc_stamper_top
  import pcds_pkg::*;
#(
  parameter int unsigned GRID_WIDTH = 256,
  parameter int unsigned MAX_RADIUS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pcds_in_if.sink    in_ch,
  pcds_out_if.source out_ch,
  pcds_cfg_if.sink   cfg
);
  localparam int unsigned DEPTH = GRID_WIDTH * GRID_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(GRID_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned OW    = RW + 1;
  localparam int unsigned D2W   = 2 * RW + 2;
  localparam int unsigned SQ_W  = 2 * RW + 2 * FRAC_W;
  localparam int unsigned SW    = RW + FRAC_W;
  localparam int unsigned PW    = $clog2(GRID_WIDTH + MAX_RADIUS + 512) + 2;
  localparam logic signed [PW-1:0] GW_S = PW'(GRID_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CENTER, S_CELL, S_SQRT, S_DIV, S_COST, S_RDWAIT, S_RMW, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [COST_W-1:0] low_cost;
  logic [COST_W-1:0] high_cost;
  logic [RAD_W-1:0]  inner_radius;
  logic [RAD_W-1:0]  outer_radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_cost     <= COST_W'(1);
      high_cost    <= COST_W'(100);
      inner_radius <= RAD_W'(0);
      outer_radius <= RAD_W'(25);
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_COST_MIN:  low_cost     <= cfg.data;
        REG_COST_MAX:  high_cost    <= cfg.data;
        REG_INNER_RAD: inner_radius <= cfg.data[RAD_W-1:0];
        REG_OUTER_RAD: outer_radius <= cfg.data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode
  logic signed [PW-1:0] in_col;
  logic signed [PW-1:0] in_row;
  logic                 in_inside;
  logic [RW-1:0]        rin_sat;
  logic [RW-1:0]        rout_sat;

  always_comb begin
    in_col    = PW'($signed(in_ch.col));
    in_row    = PW'($signed(in_ch.row));
    in_inside = (in_col >= 0) && (in_col < GW_S) && (in_row >= 0) && (in_row < GW_S);
    rin_sat   = (inner_radius > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(inner_radius);
    rout_sat  = (outer_radius > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(outer_radius);
  end

  // Item registers
  mode_t             md;
  logic              on_grid;
  logic [XW-1:0]     ctr_col;
  logic [XW-1:0]     ctr_row;
  logic [RW-1:0]     rin;
  logic [RW-1:0]     rout;
  logic signed [OW-1:0] i_off;
  logic signed [OW-1:0] j_off;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     clr_addr;
  logic [COST_W-1:0] cost_q;
  logic              out_valid;
  logic [COST_W-1:0] out_cost;
  logic              out_in_grid;

  // Offset cell evaluation
  logic signed [D2W-1:0] ie;
  logic signed [D2W-1:0] je;
  logic [D2W-1:0]        d2;
  logic [D2W-1:0]        rin_sq;
  logic [D2W-1:0]        rout_sq;
  logic signed [PW-1:0]  rpos;
  logic signed [PW-1:0]  cpos;
  logic                  cell_ok;
  logic                  cell_inner;
  logic [AW-1:0]         cell_addr_c;
  logic signed [OW-1:0]  r_last;
  logic                  last_off;

  always_comb begin
    ie          = D2W'(i_off);
    je          = D2W'(j_off);
    d2          = $unsigned(ie * ie + je * je);
    rin_sq      = D2W'(rin) * D2W'(rin);
    rout_sq     = D2W'(rout) * D2W'(rout);
    rpos        = PW'($signed({1'b0, ctr_row})) + PW'(i_off);
    cpos        = PW'($signed({1'b0, ctr_col})) + PW'(j_off);
    cell_ok     = (d2 <= rout_sq) && (rpos >= 0) && (rpos < GW_S)
                  && (cpos >= 0) && (cpos < GW_S);
    cell_inner  = (d2 < rin_sq);
    cell_addr_c = AW'(rpos[XW-1:0]) * AW'(GRID_WIDTH) + AW'(cpos[XW-1:0]);
    r_last      = OW'(rout) - OW'(1);
    last_off    = (i_off == r_last) && (j_off == r_last);
  end

  // Square root and divide units
  unit_stat_t      sq_stat;
  unit_stat_t      dv_stat;
  logic [SW-1:0]   sq_root;
  logic [SW-1:0]   dv_quot;
  logic            sq_start;
  logic            dv_start;
  logic [SQ_W-1:0] sq_arg;
  logic [SW-1:0]   dv_arg;

  assign sq_start = (state == S_CELL) && cell_ok && !cell_inner && (rout > rin);
  assign sq_arg   = {d2[2*RW-1:0], {(2 * FRAC_W){1'b0}}};
  assign dv_start = (state == S_SQRT) && sq_stat.done;
  assign dv_arg   = sq_root - {rin, {FRAC_W{1'b0}}};

  pcds_sqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_arg),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  pcds_div #(.DW(SW), .VW(RW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_arg),
    .divisor  (rout - rin),
    .stat     (dv_stat),
    .quot     (dv_quot)
  );

  // Linear falloff: low_cost + (high_cost - low_cost) * t, Q10
  logic signed [COST_W:0]       cdiff;
  logic signed [COST_W+T_W+1:0] prod;
  logic signed [COST_W+T_W+1:0] num;
  logic [COST_W-1:0]            ring_cost;

  always_comb begin
    cdiff     = $signed({1'b0, high_cost}) - $signed({1'b0, low_cost});
    prod      = cdiff * $signed({1'b0, dv_quot[T_W-1:0]});
    num       = $signed({{(T_W + 2 - FRAC_W){1'b0}}, low_cost, {FRAC_W{1'b0}}}) + prod;
    ring_cost = num[COST_W+T_W+1] ? '0 : num[COST_W+FRAC_W-1:FRAC_W];
  end

  // Grid RAM
  logic [COST_W-1:0] grid_mem [DEPTH];
  logic [COST_W-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [COST_W-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr;
    wdata = low_cost;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = high_cost;
      end
      S_CENTER: we = 1'b1;
      S_CELL: begin
        we    = cell_ok && cell_inner;
        waddr = cell_addr_c;
      end
      S_RMW: begin
        we    = 1'b1;
        wdata = (rd_data < cost_q) ? rd_data : cost_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      grid_mem[waddr] <= wdata;
    end
    rd_data <= grid_mem[cell_addr];
  end

  assign in_ch.ready = (state == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_FINISH reloads the register itself
      if (out_valid && out_ch.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            md        <= mode_t'(in_ch.mode);
            on_grid   <= in_inside;
            ctr_col   <= in_col[XW-1:0];
            ctr_row   <= in_row[XW-1:0];
            rin       <= rin_sat;
            rout      <= rout_sat;
            i_off     <= -OW'(rout_sat);
            j_off     <= -OW'(rout_sat);
            clr_addr  <= '0;
            cell_addr <= AW'(in_row[XW-1:0]) * AW'(GRID_WIDTH) + AW'(in_col[XW-1:0]);
            case (mode_t'(in_ch.mode))
              MODE_CLEAR: state <= S_CLEAR;
              MODE_STAMP: state <= in_inside ? S_CENTER : S_FINISH;
              MODE_READ:  state <= in_inside ? S_RDWAIT : S_FINISH;
              default:    state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_FINISH;
          end
        end
        S_CENTER: begin
          state <= (rout == '0) ? S_FINISH : S_CELL;
        end
        S_CELL: begin
          cell_addr <= cell_addr_c;
          cost_q    <= low_cost;
          if (cell_ok && !cell_inner) begin
            state <= (rout > rin) ? S_SQRT : S_RDWAIT;
          end else begin
            if (last_off) begin
              state <= S_FINISH;
            end
            if (j_off == r_last) begin
              j_off <= -OW'(rout);
              i_off <= i_off + 1'b1;
            end else begin
              j_off <= j_off + 1'b1;
            end
          end
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_stat.done) begin
            state <= S_COST;
          end
        end
        S_COST: begin
          cost_q <= ring_cost;
          state  <= S_RMW;
        end
        S_RDWAIT: begin
          state <= (md == MODE_READ) ? S_FINISH : S_RMW;
        end
        S_RMW: begin
          state <= last_off ? S_FINISH : S_CELL;
          if (j_off == r_last) begin
            j_off <= -OW'(rout);
            i_off <= i_off + 1'b1;
          end else begin
            j_off <= j_off + 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid   <= 1'b1;
            out_cost    <= (md == MODE_READ && on_grid) ? rd_data : '0;
            out_in_grid <= on_grid;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.cost    = out_cost;
  assign out_ch.in_grid = out_in_grid;

  // Checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("grid write while idle");

  a_sqrt_start_free: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_stat.busy && !dv_stat.busy)
    else $error("square root started while a unit is busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    dv_stat.done |-> (state == S_DIV))
    else $error("divide finished outside its wait state");

  a_ring_needs_gap: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> (rout > rin))
    else $error("ring cost computed with no ring width");

endmodule
`default_nettype wire
